>>> rtl/ffha_pkg.sv
// ffha_pkg: shared types, field widths and codes for the first-fit heap allocator.
// Used by ffha_core and first_fit_heap_allocator_unit; depends on nothing.
`default_nettype none

package ffha_pkg;

    localparam int POOL_BYTES_DEF      = 4096;
    localparam int MIN_SPLIT_BYTES_DEF = 16;

    localparam int OPCODE_W   = 2;
    localparam int SIZE_W     = 16;
    localparam int OFFSET_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int GRANT_W    = 12;
    localparam int BYTES_W    = 13;
    localparam int CHUNKS_W   = 9;
    // request size in 8-byte slots, header included: ceil(65535 / 8) + 1
    localparam int REQ_SLOT_W = 14;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_REPORT = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 2'd0,
        STS_NULL    = 2'd1,
        STS_NOSPACE = 2'd2,
        STS_BADPTR  = 2'd3
    } status_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [SIZE_W-1:0]   request_size;
        logic                pointer_null;
        logic [OFFSET_W-1:0] payload_offset;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [GRANT_W-1:0]  granted_offset;
        logic [BYTES_W-1:0]  leaked_bytes;
        logic [CHUNKS_W-1:0] leaked_chunks;
    } res_t;

    typedef struct packed {
        logic idle;
        logic done;
    } ctl_t;

endpackage

`default_nettype wire

>>> rtl/ffha_core.sv
// ffha_core: request sequencer and chunk header memory of the heap allocator.
// One walker, with its adders and comparators, visits one header per read.
// Depends on ffha_pkg.
`default_nettype none

module ffha_core #(
    parameter int POOL_BYTES      = ffha_pkg::POOL_BYTES_DEF,
    parameter int MIN_SPLIT_BYTES = ffha_pkg::MIN_SPLIT_BYTES_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire ffha_pkg::req_t req,
    input  wire logic          take,
    output ffha_pkg::ctl_t     ctl,
    output ffha_pkg::res_t     res
);

    localparam int SLOTS     = POOL_BYTES / 8;
    localparam int AW        = $clog2(SLOTS);
    localparam int CW        = AW + 1;
    localparam int EW        = CW + 1;
    localparam int MIN_SLOTS = (MIN_SPLIT_BYTES + 7) / 8;
    localparam int XW        = ffha_pkg::REQ_SLOT_W + 1;
    localparam int TW        = ffha_pkg::REQ_SLOT_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_EV   = 6'b000100,
        S_WR2  = 6'b001000,
        S_WRF  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [ffha_pkg::OPCODE_W-1:0] op_reg, op_next;
    logic [TW-1:0]        tsl_reg, tsl_next;
    logic [CW-1:0]        tgt_reg, tgt_next;
    logic [CW-1:0]        c_reg, c_next;
    logic                 phase_reg, phase_next;
    logic [CW-1:0]        s_reg, s_next;
    logic                 prev_free_reg, prev_free_next;
    logic [CW-1:0]        prev_c_reg, prev_c_next;
    logic [CW-1:0]        prev_s_reg, prev_s_next;
    logic [CW-1:0]        bytes_reg, bytes_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    ffha_pkg::res_t       res_reg, res_next;
    logic                 init_reg;
    logic                 rd_zero_reg;
    logic [EW-1:0]        rdata_reg;

    logic [EW-1:0]        mem [SLOTS];
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic [EW-1:0]        mem_wd;
    logic                 mem_re;

    logic [EW-1:0]        h;
    logic [CW-1:0]        h_s;
    logic                 h_a;
    logic [CW-1:0]        sum;
    logic                 at_end;
    logic                 fit;
    logic [CW-1:0]        rem;
    logic                 split;
    logic [16:0]          pad;
    logic                 off_bad;
    logic [CW-1:0]        b_new, n_new;
    logic [31:0]          g32, b32, n32;

    // entry 0 reads as one free chunk over the whole pool until first written
    assign h      = rd_zero_reg ? {CW'(SLOTS), 1'b0} : rdata_reg;
    assign h_s    = h[EW-1:1];
    assign h_a    = h[0];
    assign sum    = c_reg + h_s;
    assign at_end = sum >= CW'(SLOTS);
    assign fit    = !h_a && (XW'(h_s) >= XW'(tsl_reg));
    assign rem    = h_s - CW'(tsl_reg);
    assign split  = rem >= CW'(MIN_SLOTS);
    assign pad    = {1'b0, req.request_size} + 17'd7;
    assign off_bad = ({1'b0, req.payload_offset} >= 17'(POOL_BYTES))
                  || (req.payload_offset[15:3] == 13'd0)
                  || (req.payload_offset[2:0] != 3'd0);
    assign b_new  = h_a ? bytes_reg + h_s - CW'(1) : bytes_reg;
    assign n_new  = h_a ? cnt_reg + CW'(1) : cnt_reg;
    assign g32    = (32'(c_reg) + 32'd1) << 3;
    assign b32    = 32'(b_new) << 3;
    assign n32    = 32'(n_new);

    assign mem_re = (state_reg == S_RD);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = c_reg[AW-1:0];
        mem_wd = {h_s, 1'b1};
        case (state_reg)
            S_EV: begin
                if (op_reg == ffha_pkg::OP_ALLOC && fit) begin
                    mem_we = 1'b1;
                    mem_wd = split ? {CW'(tsl_reg), 1'b1} : {h_s, 1'b1};
                end
            end
            S_WR2: begin
                mem_we = 1'b1;
                mem_wd = {s_reg, 1'b0};
            end
            S_WRF: begin
                mem_we = 1'b1;
                if (prev_free_reg) begin
                    mem_wa = prev_c_reg[AW-1:0];
                    mem_wd = {prev_s_reg + s_reg, 1'b0};
                end else begin
                    mem_wa = tgt_reg[AW-1:0];
                    mem_wd = {s_reg, 1'b0};
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        tsl_next       = tsl_reg;
        tgt_next       = tgt_reg;
        c_next         = c_reg;
        phase_next     = phase_reg;
        s_next         = s_reg;
        prev_free_next = prev_free_reg;
        prev_c_next    = prev_c_reg;
        prev_s_next    = prev_s_reg;
        bytes_next     = bytes_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    op_next        = req.opcode;
                    tsl_next       = TW'(pad[16:3]) + TW'(1);
                    tgt_next       = CW'(req.payload_offset[15:3] - 13'd1);
                    c_next         = '0;
                    phase_next     = 1'b0;
                    prev_free_next = 1'b0;
                    bytes_next     = '0;
                    cnt_next       = '0;
                    res_next       = '0;
                    res_next.status = ffha_pkg::STS_NULL;
                    state_next     = S_DONE;
                    case (req.opcode)
                        ffha_pkg::OP_ALLOC: begin
                            if (req.request_size != '0) begin
                                state_next = S_RD;
                            end
                        end
                        ffha_pkg::OP_FREE: begin
                            if (!req.pointer_null) begin
                                if (off_bad) begin
                                    res_next.status = ffha_pkg::STS_BADPTR;
                                end else begin
                                    state_next = S_RD;
                                end
                            end
                        end
                        ffha_pkg::OP_REPORT: begin
                            state_next = S_RD;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RD: begin
                state_next = S_EV;
            end
            S_EV: begin
                case (op_reg)
                    ffha_pkg::OP_ALLOC: begin
                        if (fit) begin
                            res_next.status         = ffha_pkg::STS_OK;
                            res_next.granted_offset = g32[ffha_pkg::GRANT_W-1:0];
                            if (split) begin
                                c_next     = c_reg + CW'(tsl_reg);
                                s_next     = rem;
                                state_next = S_WR2;
                            end else begin
                                state_next = S_DONE;
                            end
                        end else if (at_end) begin
                            res_next.status = ffha_pkg::STS_NOSPACE;
                            state_next      = S_DONE;
                        end else begin
                            c_next     = sum;
                            state_next = S_RD;
                        end
                    end
                    ffha_pkg::OP_FREE: begin
                        if (phase_reg) begin
                            if (!h_a) begin
                                s_next = s_reg + h_s;
                            end
                            state_next = S_WRF;
                        end else if (c_reg > tgt_reg) begin
                            res_next.status = ffha_pkg::STS_BADPTR;
                            state_next      = S_DONE;
                        end else if (c_reg == tgt_reg) begin
                            if (h_a) begin
                                s_next = h_s;
                                if (at_end) begin
                                    state_next = S_WRF;
                                end else begin
                                    c_next     = sum;
                                    phase_next = 1'b1;
                                    state_next = S_RD;
                                end
                            end else begin
                                res_next.status = ffha_pkg::STS_BADPTR;
                                state_next      = S_DONE;
                            end
                        end else begin
                            prev_c_next    = c_reg;
                            prev_s_next    = h_s;
                            prev_free_next = !h_a;
                            c_next         = sum;
                            if (at_end) begin
                                res_next.status = ffha_pkg::STS_BADPTR;
                                state_next      = S_DONE;
                            end else begin
                                state_next = S_RD;
                            end
                        end
                    end
                    default: begin
                        bytes_next = b_new;
                        cnt_next   = n_new;
                        c_next     = sum;
                        if (at_end) begin
                            res_next.status        = ffha_pkg::STS_OK;
                            res_next.leaked_bytes  = b32[ffha_pkg::BYTES_W-1:0];
                            res_next.leaked_chunks = n32[ffha_pkg::CHUNKS_W-1:0];
                            state_next             = S_DONE;
                        end else begin
                            state_next = S_RD;
                        end
                    end
                endcase
            end
            S_WR2: begin
                state_next = S_DONE;
            end
            S_WRF: begin
                res_next.status = ffha_pkg::STS_OK;
                state_next      = S_DONE;
            end
            S_DONE: begin
                if (take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            init_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mem_we && mem_wa == '0) begin
                init_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        tsl_reg       <= tsl_next;
        tgt_reg       <= tgt_next;
        c_reg         <= c_next;
        phase_reg     <= phase_next;
        s_reg         <= s_next;
        prev_free_reg <= prev_free_next;
        prev_c_reg    <= prev_c_next;
        prev_s_reg    <= prev_s_next;
        bytes_reg     <= bytes_next;
        cnt_reg       <= cnt_next;
        res_reg       <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rdata_reg   <= mem[c_reg[AW-1:0]];
            rd_zero_reg <= (c_reg[AW-1:0] == '0) && !init_reg;
        end
    end

    assign ctl.idle = (state_reg == S_IDLE);
    assign ctl.done = (state_reg == S_DONE);
    assign res      = res_reg;

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !mem_we)
        else $error("header write while idle");

    a_walk_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RD |-> c_reg < CW'(SLOTS))
        else $error("walker beyond pool");

    a_start_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start && ctl.idle |=> state_reg != S_IDLE)
        else $error("transaction accepted but not started");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.done && !take |=> ctl.done && $stable(res_reg))
        else $error("result changed before hand-off");

endmodule

`default_nettype wire

>>> rtl/first_fit_heap_allocator_unit.sv
// Heap allocator top: one request transaction at a time over an implicit chunk list,
// with a registered result stage so a finished result can wait while the next request runs.
// Depends on ffha_pkg and ffha_core.
//
// A request visits chunk headers one by one from offset 0, reading and then evaluating
// each, then makes its decision and any write-back; null requests and frees with a
// malformed offset skip the walk. With 512 slots a pool holds at most 256 chunks. The
// walk is paced by the single-port header memory, whose registered read feeds one
// shared add/compare walker. No clearing pass is needed after reset.
`default_nettype none

module first_fit_heap_allocator_unit #(
    parameter int POOL_BYTES      = ffha_pkg::POOL_BYTES_DEF,
    parameter int MIN_SPLIT_BYTES = ffha_pkg::MIN_SPLIT_BYTES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [ffha_pkg::OPCODE_W-1:0] s_opcode,
    input  wire logic [ffha_pkg::SIZE_W-1:0]   s_request_size,
    input  wire logic                          s_pointer_null,
    input  wire logic [ffha_pkg::OFFSET_W-1:0] s_payload_offset,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [ffha_pkg::STATUS_W-1:0]      m_status,
    output logic [ffha_pkg::GRANT_W-1:0]       m_granted_offset,
    output logic [ffha_pkg::BYTES_W-1:0]       m_leaked_bytes,
    output logic [ffha_pkg::CHUNKS_W-1:0]      m_leaked_chunks
);

    ffha_pkg::req_t req;
    ffha_pkg::res_t res;
    ffha_pkg::ctl_t ctl;
    ffha_pkg::res_t out_reg;
    logic           m_valid_reg;
    logic           start;
    logic           take;

    assign req.opcode         = s_opcode;
    assign req.request_size   = s_request_size;
    assign req.pointer_null   = s_pointer_null;
    assign req.payload_offset = s_payload_offset;

    assign s_ready = ctl.idle;
    assign start   = s_valid && ctl.idle;
    assign take    = ctl.done && (!m_valid_reg || m_ready);

    ffha_core #(
        .POOL_BYTES      (POOL_BYTES),
        .MIN_SPLIT_BYTES (MIN_SPLIT_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .req     (req),
        .take    (take),
        .ctl     (ctl),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = out_reg.status;
    assign m_granted_offset = out_reg.granted_offset;
    assign m_leaked_bytes   = out_reg.leaked_bytes;
    assign m_leaked_chunks  = out_reg.leaked_chunks;

endmodule

`default_nettype wire

>>> bench/first_fit_heap_allocator_unit_tb.sv
// Self-checking bench for first_fit_heap_allocator_unit: directed and random heap
// transactions, with results predicted against a local header store. Depends on ffha_pkg.
`default_nettype none

module first_fit_heap_allocator_unit_tb;

    localparam int unsigned POOL        = ffha_pkg::POOL_BYTES_DEF;
    localparam int unsigned SPLIT_MIN   = ffha_pkg::MIN_SPLIT_BYTES_DEF;
    localparam int unsigned HDR         = 8;
    localparam int unsigned SLOTS       = POOL / 8;
    localparam int          RANDOM_ITEMS   = 540;
    localparam int          SETTLE_CYCLES  = 1100;
    localparam int          TIMEOUT_CYCLES = 3_000_000;
    localparam logic [ffha_pkg::OPCODE_W-1:0] OP_UNDEFINED = 2'd3;

    typedef struct {
        ffha_pkg::req_t req;
        ffha_pkg::res_t result;
        int unsigned    phase;
        bit             drain;
    } heap_txn_t;

    logic                          aclk    = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [ffha_pkg::OPCODE_W-1:0] s_opcode         = '0;
    logic [ffha_pkg::SIZE_W-1:0]   s_request_size   = '0;
    logic                          s_pointer_null   = 1'b0;
    logic [ffha_pkg::OFFSET_W-1:0] s_payload_offset = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [ffha_pkg::STATUS_W-1:0] m_status;
    logic [ffha_pkg::GRANT_W-1:0]  m_granted_offset;
    logic [ffha_pkg::BYTES_W-1:0]  m_leaked_bytes;
    logic [ffha_pkg::CHUNKS_W-1:0] m_leaked_chunks;

    logic [13:0]     heap_hdr [SLOTS];
    heap_txn_t       request_backlog [$];
    ffha_pkg::res_t  awaited_outcomes [$];
    int unsigned     live_offsets [$];
    int unsigned     fill_phase  = 0;
    bit              drain_next  = 1'b0;
    int unsigned     cur_phase   = 0;
    int unsigned     mismatch_count = 0;
    int unsigned     results_seen   = 0;
    int unsigned     send_idle_pct  [4] = '{0, 53, 0, 38};
    int unsigned     recv_stall_pct [4] = '{0, 0, 53, 38};

    first_fit_heap_allocator_unit i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_request_size   (s_request_size),
        .s_pointer_null   (s_pointer_null),
        .s_payload_offset (s_payload_offset),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_granted_offset (m_granted_offset),
        .m_leaked_bytes   (m_leaked_bytes),
        .m_leaked_chunks  (m_leaked_chunks)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic int unsigned chunk_word(int unsigned off);
        return (off / 8 < SLOTS) ? int'(heap_hdr[off / 8]) : 0;
    endfunction

    // Applies one request to the header store and returns its outcome.
    function automatic ffha_pkg::res_t heap_outcome(ffha_pkg::req_t r);
        ffha_pkg::res_t res;
        int unsigned    c, h, s, total, target, nh, ph, b, n;
        bit             found;
        res = '0;
        res.status = ffha_pkg::STS_NULL;
        case (r.opcode)
            ffha_pkg::OP_ALLOC: begin
                if (r.request_size != 0) begin
                    total = (({16'd0, r.request_size} + 32'd7) & ~32'd7) + HDR;
                    res.status = ffha_pkg::STS_NOSPACE;
                    c = 0;
                    while (c < POOL) begin
                        h = chunk_word(c);
                        s = h & ~32'd7;
                        if (s == 0)
                            break;
                        if (!h[0] && s >= total) begin
                            if (s - total >= SPLIT_MIN) begin
                                heap_hdr[c / 8] = 14'(total | 1);
                                heap_hdr[(c + total) / 8] = 14'(s - total);
                            end else begin
                                heap_hdr[c / 8] = 14'(s | 1);
                            end
                            res.status = ffha_pkg::STS_OK;
                            res.granted_offset = ffha_pkg::GRANT_W'(c + HDR);
                            break;
                        end
                        c += s;
                    end
                end
            end
            ffha_pkg::OP_FREE: begin
                if (!r.pointer_null) begin
                    res.status = ffha_pkg::STS_BADPTR;
                    found = 1'b0;
                    s = 0;
                    if (r.payload_offset < POOL && r.payload_offset >= HDR) begin
                        target = r.payload_offset - HDR;
                        c = 0;
                        while (c < POOL) begin
                            h = chunk_word(c);
                            s = h & ~32'd7;
                            if (s == 0 || c > target)
                                break;
                            if (c == target) begin
                                found = h[0];
                                break;
                            end
                            c += s;
                        end
                    end
                    if (found) begin
                        if (target + s < POOL) begin
                            nh = chunk_word(target + s);
                            if ((nh & ~32'd7) != 0 && !nh[0])
                                s += nh & ~32'd7;
                        end
                        heap_hdr[target / 8] = 14'(s);
                        c = 0;
                        while (c < target) begin
                            ph = chunk_word(c);
                            if ((ph & ~32'd7) == 0)
                                break;
                            if (c + (ph & ~32'd7) == target) begin
                                if (!ph[0])
                                    heap_hdr[c / 8] = 14'((ph & ~32'd7) + s);
                                break;
                            end
                            c += ph & ~32'd7;
                        end
                        res.status = ffha_pkg::STS_OK;
                    end
                end
            end
            ffha_pkg::OP_REPORT: begin
                c = 0;
                b = 0;
                n = 0;
                while (c < POOL) begin
                    h = chunk_word(c);
                    s = h & ~32'd7;
                    if (s == 0)
                        break;
                    if (h[0]) begin
                        b += s - HDR;
                        n++;
                    end
                    c += s;
                end
                res.status = ffha_pkg::STS_OK;
                res.leaked_bytes = ffha_pkg::BYTES_W'(b);
                res.leaked_chunks = ffha_pkg::CHUNKS_W'(n);
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic queue_request(logic [ffha_pkg::OPCODE_W-1:0] op, int unsigned size,
                                 bit pnull, int unsigned off);
        heap_txn_t t;
        t.req.opcode         = op;
        t.req.request_size   = ffha_pkg::SIZE_W'(size);
        t.req.pointer_null   = pnull;
        t.req.payload_offset = ffha_pkg::OFFSET_W'(off);
        t.result = heap_outcome(t.req);
        t.phase  = fill_phase;
        t.drain  = drain_next;
        drain_next = 1'b0;
        if (op == ffha_pkg::OP_ALLOC && t.result.status == ffha_pkg::STS_OK)
            live_offsets.push_back(t.result.granted_offset);
        if (op == ffha_pkg::OP_FREE && t.result.status == ffha_pkg::STS_OK) begin
            foreach (live_offsets[i]) begin
                if (live_offsets[i] == t.req.payload_offset) begin
                    live_offsets.delete(i);
                    break;
                end
            end
        end
        request_backlog.push_back(t);
    endtask

    // Driver
    always @(posedge aclk) begin
        bit holding;
        bit launch;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            holding = s_valid && !s_ready;
            if (s_valid && s_ready) begin
                awaited_outcomes.push_back(request_backlog[0].result);
                void'(request_backlog.pop_front());
            end
            if (!holding) begin
                launch = request_backlog.size() != 0;
                if (launch && request_backlog[0].drain && awaited_outcomes.size() != 0)
                    launch = 1'b0;
                if (launch && $urandom_range(99) < send_idle_pct[request_backlog[0].phase])
                    launch = 1'b0;
                s_valid <= launch;
                if (launch) begin
                    s_opcode         <= request_backlog[0].req.opcode;
                    s_request_size   <= request_backlog[0].req.request_size;
                    s_pointer_null   <= request_backlog[0].req.pointer_null;
                    s_payload_offset <= request_backlog[0].req.payload_offset;
                    cur_phase        <= request_backlog[0].phase;
                end
            end
        end
    end

    // Monitor
    always @(posedge aclk) begin
        ffha_pkg::res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_outcomes.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("result %0d: transaction with nothing outstanding",
                                 results_seen);
                    mismatch_count++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (m_status !== want.status
                            || m_granted_offset !== want.granted_offset
                            || m_leaked_bytes !== want.leaked_bytes
                            || m_leaked_chunks !== want.leaked_chunks) begin
                        if (mismatch_count < 10)
                            $display({"result %0d: expected sts %0d off %0d bytes %0d ",
                                      "chunks %0d, got sts %0d off %0d bytes %0d chunks %0d"},
                                     results_seen, want.status, want.granted_offset,
                                     want.leaked_bytes, want.leaked_chunks, m_status,
                                     m_granted_offset, m_leaked_bytes, m_leaked_chunks);
                        mismatch_count++;
                    end
                end
                results_seen++;
            end
            m_ready <= $urandom_range(99) >= recv_stall_pct[cur_phase];
        end
    end

    initial begin
        int unsigned pick, sel, size, off, last_freed, free_bias;
        last_freed = 8;
        for (int i = 0; i < SLOTS; i++)
            heap_hdr[i] = '0;
        heap_hdr[0] = 14'(POOL);

        queue_request(ffha_pkg::OP_REPORT, 0, 0, 0);
        queue_request(ffha_pkg::OP_ALLOC, 0, 0, 0);
        queue_request(ffha_pkg::OP_ALLOC, 16'hFFFF, 1, 16'hFFFF);
        queue_request(ffha_pkg::OP_ALLOC, 4088, 0, 0);
        queue_request(ffha_pkg::OP_ALLOC, 1, 0, 0);
        queue_request(ffha_pkg::OP_REPORT, 0, 0, 0);
        queue_request(ffha_pkg::OP_FREE, 0, 0, 8);
        queue_request(ffha_pkg::OP_FREE, 0, 0, 8);
        queue_request(ffha_pkg::OP_FREE, 16'hFFFF, 1, 16'hFFFF);
        queue_request(OP_UNDEFINED, 16'hFFFF, 1, 16'hFFFF);
        queue_request(ffha_pkg::OP_ALLOC, 1, 0, 0);
        queue_request(ffha_pkg::OP_ALLOC, 24, 0, 0);
        queue_request(ffha_pkg::OP_ALLOC, 100, 0, 0);
        queue_request(ffha_pkg::OP_FREE, 0, 0, 30);
        queue_request(ffha_pkg::OP_FREE, 0, 0, POOL);
        queue_request(ffha_pkg::OP_FREE, 0, 0, 4);
        queue_request(ffha_pkg::OP_FREE, 0, 0, 24);
        queue_request(ffha_pkg::OP_FREE, 0, 0, 8);
        queue_request(ffha_pkg::OP_FREE, 0, 0, 56);
        queue_request(ffha_pkg::OP_ALLOC, 4080, 0, 0);
        queue_request(ffha_pkg::OP_REPORT, 0, 0, 0);
        queue_request(ffha_pkg::OP_FREE, 0, 0, 8);
        queue_request(ffha_pkg::OP_ALLOC, 4072, 0, 0);
        queue_request(ffha_pkg::OP_ALLOC, 1, 0, 0);
        queue_request(ffha_pkg::OP_REPORT, 0, 0, 0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            fill_phase = n * 4 / RANDOM_ITEMS;
            if (n % (RANDOM_ITEMS / 4) == 0)
                drain_next = 1'b1;
            free_bias = (live_offsets.size() > 40) ? 25 : 0;
            pick = $urandom_range(99);
            sel  = $urandom_range(99);
            if (pick < 42 - free_bias) begin
                if (sel < 70)
                    size = $urandom_range(64, 1);
                else if (sel < 88)
                    size = $urandom_range(512, 65);
                else if (sel < 94)
                    size = $urandom_range(65535, 0);
                else if (sel < 98)
                    size = $urandom_range(4088, 513);
                else
                    size = 0;
                queue_request(ffha_pkg::OP_ALLOC, size, $urandom_range(1),
                              $urandom_range(65535));
            end else if (pick < 80) begin
                if (sel < 70 && live_offsets.size() != 0) begin
                    off = live_offsets[$urandom_range(live_offsets.size() - 1)];
                    last_freed = off;
                end else if (sel < 78 && live_offsets.size() != 0) begin
                    // inside a live chunk or at the start of a neighbour
                    off = live_offsets[$urandom_range(live_offsets.size() - 1)]
                          + $urandom_range(40, 1);
                end else if (sel < 86) begin
                    off = last_freed;
                end else if (sel < 94) begin
                    off = $urandom_range(65535);
                end else begin
                    queue_request(ffha_pkg::OP_FREE, $urandom_range(65535), 1,
                                  $urandom_range(65535));
                    continue;
                end
                queue_request(ffha_pkg::OP_FREE, $urandom_range(65535), 0, off);
            end else if (pick < 94) begin
                queue_request(ffha_pkg::OP_REPORT, $urandom_range(65535), $urandom_range(1),
                              $urandom_range(65535));
            end else begin
                queue_request(OP_UNDEFINED, $urandom_range(65535), $urandom_range(1),
                              $urandom_range(65535));
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (request_backlog.size() != 0 || awaited_outcomes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
